FILE: src/lptg_pkg.sv
`timescale 1ns / 1ps
// lptg_pkg: sizes, register indexes, transaction types and the quarter-wave sine table
// shared by the front, queue, back and top modules; depends on nothing else
package lptg_pkg;

    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int TRIG_FRAC_BITS = 16;

    localparam int QSIN_W  = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int PROD_W  = TRIG_FRAC_BITS + 14;
    localparam int MAG_W   = PROD_W - TRIG_FRAC_BITS;
    localparam int CELLS   = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int QUARTER = 91;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam int DIST_W  = 12;
    localparam int ANGLE_W = 9;
    localparam int POS_W   = 8;
    localparam int SIZE_W  = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [1:9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    typedef struct packed {
        logic [POS_W-1:0]  robot_x;
        logic [POS_W-1:0]  robot_y;
        logic [SIZE_W-1:0] grid_width;
        logic [SIZE_W-1:0] grid_height;
    } lptg_cfg_t;

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } lptg_trig_ref_t;

    typedef struct packed {
        logic [POS_W-1:0]  cell_x;
        logic [POS_W-1:0]  cell_y;
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
    } lptg_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lptg_qstat_t;

    // sine in Q2.30 by Taylor series, rounded half up to the table precision
    function automatic logic [QSIN_W-1:0] qsin_calc(input int d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        sum = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        return sum[QSIN_W-1:0];
    endfunction

    function automatic logic [QUARTER*QSIN_W-1:0] build_qsin_tab();
        logic [QUARTER*QSIN_W-1:0] t;
        t = '0;
        for (int d = 0; d < QUARTER; d++)
        begin
            t[d*QSIN_W +: QSIN_W] = qsin_calc(d);
        end
        return t;
    endfunction

    localparam logic [QUARTER*QSIN_W-1:0] QSIN_TAB = build_qsin_tab();

    function automatic logic [QSIN_W-1:0] qsin_lookup(input logic [6:0] idx);
        return QSIN_TAB[idx*QSIN_W +: QSIN_W];
    endfunction

    // quadrant fold of an angle in 0..359 onto the quarter table
    function automatic lptg_trig_ref_t trig_select(input logic [ANGLE_W-1:0] d);
        lptg_trig_ref_t r;
        if (d < DEG_90)
        begin
            r.neg = 1'b0;
            r.idx = d[6:0];
        end
        else if (d < DEG_180)
        begin
            r.neg = 1'b0;
            r.idx = 7'(DEG_180 - d);
        end
        else if (d < DEG_270)
        begin
            r.neg = 1'b1;
            r.idx = 7'(d - DEG_180);
        end
        else
        begin
            r.neg = 1'b1;
            r.idx = 7'(DEG_360 - d);
        end
        return r;
    endfunction

endpackage

FILE: src/lptg_front.sv
`timescale 1ns / 1ps
// lptg_front: accepts readings, looks up cos/sin, forms and classifies the grid point
// depends on lptg_pkg; feeds lptg_queue
module lptg_front
    import lptg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lptg_cfg_t           cfg,
    input  logic                clr_busy,
    input  logic                q_full,
    input  logic                reading_valid,
    output logic                reading_stall,
    input  logic [DIST_W-1:0]   distance,
    input  logic [ANGLE_W-1:0]  angle_deg,
    output logic                push,
    output lptg_entry_t         push_entry
);

    logic adv;
    logic accept;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;

    logic [ANGLE_W-1:0] a_red;
    logic [ANGLE_W:0]   a_sum;
    logic [ANGLE_W-1:0] a_cos;

    logic [DIST_W-1:0] s1_dist_reg;
    lptg_trig_ref_t    s1_cos_reg;
    lptg_trig_ref_t    s1_sin_reg;

    logic signed [TRIG_W-1:0] cos_mag;
    logic signed [TRIG_W-1:0] sin_mag;
    logic signed [TRIG_W-1:0] s2_cos_next;
    logic signed [TRIG_W-1:0] s2_sin_next;
    logic signed [TRIG_W-1:0] s2_cos_reg;
    logic signed [TRIG_W-1:0] s2_sin_reg;
    logic [DIST_W-1:0]        s2_dist_reg;

    logic signed [PROD_W-1:0] s3_px_next;
    logic signed [PROD_W-1:0] s3_py_next;
    logic signed [PROD_W-1:0] s3_px_reg;
    logic signed [PROD_W-1:0] s3_py_reg;

    logic [PROD_W-1:0] abs_x;
    logic [PROD_W-1:0] abs_y;
    logic [MAG_W-1:0]  s4_mx_reg;
    logic [MAG_W-1:0]  s4_my_reg;
    logic              s4_nx_reg;
    logic              s4_ny_reg;

    logic neg_x;
    logic neg_y;
    logic ok_x;
    logic ok_y;
    logic in_grid;

    assign adv           = !(s4_valid_reg && q_full);
    assign reading_stall = !adv || clr_busy;
    assign accept        = reading_valid && !reading_stall;

    always_comb
    begin
        a_red = (angle_deg >= DEG_360) ? ANGLE_W'(angle_deg - DEG_360) : angle_deg;
        a_sum = {1'b0, a_red} + {1'b0, DEG_90};
        a_cos = (a_sum >= {1'b0, DEG_360}) ? ANGLE_W'(a_sum - {1'b0, DEG_360})
                                           : a_sum[ANGLE_W-1:0];
    end

    always_comb
    begin
        cos_mag     = $signed(TRIG_W'(qsin_lookup(s1_cos_reg.idx)));
        sin_mag     = $signed(TRIG_W'(qsin_lookup(s1_sin_reg.idx)));
        s2_cos_next = s1_cos_reg.neg ? -cos_mag : cos_mag;
        s2_sin_next = s1_sin_reg.neg ? -sin_mag : sin_mag;
    end

    always_comb
    begin
        s3_px_next = $signed(PROD_W'({cfg.robot_x, {TRIG_FRAC_BITS{1'b0}}}))
                   + PROD_W'($signed({1'b0, s2_dist_reg})) * PROD_W'(s2_cos_reg);
        s3_py_next = $signed(PROD_W'({cfg.robot_y, {TRIG_FRAC_BITS{1'b0}}}))
                   + PROD_W'($signed({1'b0, s2_dist_reg})) * PROD_W'(s2_sin_reg);
    end

    // truncation toward zero: work on the magnitude
    always_comb
    begin
        abs_x = s3_px_reg[PROD_W-1] ? PROD_W'(-s3_px_reg) : PROD_W'(s3_px_reg);
        abs_y = s3_py_reg[PROD_W-1] ? PROD_W'(-s3_py_reg) : PROD_W'(s3_py_reg);
    end

    always_comb
    begin
        neg_x   = s4_nx_reg && (s4_mx_reg != '0);
        neg_y   = s4_ny_reg && (s4_my_reg != '0);
        ok_x    = !neg_x && (s4_mx_reg < MAG_W'(cfg.grid_width))
                         && (s4_mx_reg < MAG_W'(MAX_COLS));
        ok_y    = !neg_y && (s4_my_reg < MAG_W'(cfg.grid_height))
                         && (s4_my_reg < MAG_W'(MAX_ROWS));
        in_grid = ok_x && ok_y;

        push_entry.in_grid = in_grid;
        push_entry.cell_x  = in_grid ? s4_mx_reg[POS_W-1:0] : '0;
        push_entry.cell_y  = in_grid ? s4_my_reg[POS_W-1:0] : '0;
        push_entry.addr    = in_grid ? ADDR_W'(32'(s4_my_reg) * MAX_COLS + 32'(s4_mx_reg))
                                     : '0;
    end

    assign push = s4_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dist_reg <= distance;
            s1_cos_reg  <= trig_select(a_cos);
            s1_sin_reg  <= trig_select(a_red);
            s2_dist_reg <= s1_dist_reg;
            s2_cos_reg  <= s2_cos_next;
            s2_sin_reg  <= s2_sin_next;
            s3_px_reg   <= s3_px_next;
            s3_py_reg   <= s3_py_next;
            s4_mx_reg   <= abs_x[PROD_W-1:TRIG_FRAC_BITS];
            s4_my_reg   <= abs_y[PROD_W-1:TRIG_FRAC_BITS];
            s4_nx_reg   <= s3_px_reg[PROD_W-1];
            s4_ny_reg   <= s3_py_reg[PROD_W-1];
        end
    end

endmodule

FILE: src/lptg_queue.sv
`timescale 1ns / 1ps
// lptg_queue: short fifo of classified points between front and back
// depends on lptg_pkg
module lptg_queue
    import lptg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lptg_entry_t push_entry,
    input  logic        pop,
    output lptg_entry_t head,
    output lptg_qstat_t stat
);

    lptg_entry_t       slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head       = slots[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: src/lptg_back.sv
`timescale 1ns / 1ps
// lptg_back: occupancy bitmap with read-and-set per point, clearing pass, result register
// depends on lptg_pkg; drained from lptg_queue
module lptg_back
    import lptg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lptg_entry_t       q_head,
    input  lptg_qstat_t       q_stat,
    output logic              pop,
    output logic              clr_busy,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [POS_W-1:0]  cell_x,
    output logic [POS_W-1:0]  cell_y,
    output logic              inside_res,
    output logic              already_marked
);

    logic              occ_mem [CELLS];
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_last;

    logic              out_valid_reg;
    logic [POS_W-1:0]  cell_x_reg;
    logic [POS_W-1:0]  cell_y_reg;
    logic              inside_reg;
    logic              prev_reg;

    assign clr_last = (clr_cnt_reg == ADDR_W'(CELLS - 1));
    assign clr_busy = clr_busy_reg;
    assign pop      = !clr_busy_reg && !q_stat.empty && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_last)
                clr_busy_reg <= 1'b0;
        end
    end

    // old bit is read while the new one is written at the same address
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            occ_mem[clr_cnt_reg] <= 1'b0;
        else if (pop)
        begin
            if (q_head.in_grid)
                occ_mem[q_head.addr] <= 1'b1;
            prev_reg <= occ_mem[q_head.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cell_x_reg <= q_head.cell_x;
            cell_y_reg <= q_head.cell_y;
            inside_reg <= q_head.in_grid;
        end
    end

    assign result_valid   = out_valid_reg;
    assign cell_x         = cell_x_reg;
    assign cell_y         = cell_y_reg;
    assign inside_res     = inside_reg;
    assign already_marked = inside_reg && prev_reg;

endmodule

FILE: src/lidar_polar_to_grid_marker.sv
`timescale 1ns / 1ps
// lidar_polar_to_grid_marker: top level, configuration registers and the three parts
// depends on lptg_pkg, lptg_front, lptg_queue, lptg_back
//
//   channel   handshake                      payload
//   reading   reading_valid / reading_stall  distance, angle_deg
//   result    result_valid / result_stall    cell_x, cell_y, inside_res, already_marked
//   config    cfg_we                         cfg_index, cfg_data
//
// one transaction per cycle unless result_stall or clearing holds it; reading to result
// (four front stages, queue, bitmap read-and-set into the result register)
// after reset the bitmap is cleared one cell per cycle, all MAX_COLS * MAX_ROWS cells
// (65536 at the default size), with reading_stall high; config writes are taken meanwhile
// result_stall fills the four-entry queue, then the front holds and raises reading_stall
module lidar_polar_to_grid_marker
    import lptg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  reading_valid,
    output logic                  reading_stall,
    input  logic [DIST_W-1:0]     distance,
    input  logic [ANGLE_W-1:0]    angle_deg,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [POS_W-1:0]      cell_x,
    output logic [POS_W-1:0]      cell_y,
    output logic                  inside_res,
    output logic                  already_marked
);

    lptg_cfg_t   cfg_reg;
    logic        clr_busy;
    logic        push;
    logic        pop;
    lptg_entry_t push_entry;
    lptg_entry_t q_head;
    lptg_qstat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.robot_x     <= '0;
            cfg_reg.robot_y     <= '0;
            cfg_reg.grid_width  <= GRID_SIZE_RESET;
            cfg_reg.grid_height <= GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROBOT_X:     cfg_reg.robot_x     <= cfg_data[POS_W-1:0];
                REG_ROBOT_Y:     cfg_reg.robot_y     <= cfg_data[POS_W-1:0];
                REG_GRID_WIDTH:  cfg_reg.grid_width  <= cfg_data[SIZE_W-1:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    lptg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clr_busy      (clr_busy),
        .q_full        (q_stat.full),
        .reading_valid (reading_valid),
        .reading_stall (reading_stall),
        .distance      (distance),
        .angle_deg     (angle_deg),
        .push          (push),
        .push_entry    (push_entry)
    );

    lptg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    lptg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .q_stat         (q_stat),
        .pop            (pop),
        .clr_busy       (clr_busy),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .inside_res     (inside_res),
        .already_marked (already_marked)
    );

endmodule
